// ===== rtl/shd_pkg.sv =====
// ----------------------------------------------------------------------------
// shd_pkg: shared types and constants for the double SHA-256 nonce test
// Round constants, initial hash value and the round and schedule functions.
// ----------------------------------------------------------------------------
package shd_pkg;

    localparam int unsigned NUM_ROUNDS = 64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam logic [4:0] IDX_TAIL_BASE = 5'd8;
    localparam logic [4:0] IDX_TGT_BASE  = 5'd11;
    localparam logic [4:0] IDX_LAST      = 5'd18;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] state_t;
    typedef word_t [15:0] sched_t;

    localparam word_t ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // state_t index 0 holds word a
    localparam state_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t swap_bytes(input word_t v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // One compression round on working variables a..h (index 0..7)
    function automatic state_t sha_round(input state_t s, input word_t k, input word_t w);
        word_t t1;
        word_t t2;
        state_t r;
        t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + k + w;
        t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        r[7] = s[6];
        r[6] = s[5];
        r[5] = s[4];
        r[4] = s[3] + t1;
        r[3] = s[2];
        r[2] = s[1];
        r[1] = s[0];
        r[0] = t1 + t2;
        sha_round = r;
    endfunction

    // Slide the 16-word schedule window by one word
    function automatic sched_t sched_shift(input sched_t w);
        word_t s0;
        word_t s1;
        sched_t r;
        s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
        s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        for (int i = 0; i < 15; i++) begin
            r[i] = w[i + 1];
        end
        r[15] = w[0] + s0 + w[9] + s1;
        sched_shift = r;
    endfunction

    function automatic state_t state_add(input state_t a, input state_t b);
        state_t r;
        for (int i = 0; i < 8; i++) begin
            r[i] = a[i] + b[i];
        end
        state_add = r;
    endfunction

endpackage

// ===== rtl/shd_round_cell.sv =====
// ----------------------------------------------------------------------------
// shd_round_cell: one SHA-256 round cell of the unrolled chain
// Applies one round, slides the schedule window, carries the side data along.
// ----------------------------------------------------------------------------
module shd_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  shd_pkg::state_t in_state,
    input  shd_pkg::sched_t in_sched,
    input  shd_pkg::state_t in_base,
    input  logic [31:0]     in_nonce,
    output logic            out_valid,
    output shd_pkg::state_t out_state,
    output shd_pkg::sched_t out_sched,
    output shd_pkg::state_t out_base,
    output logic [31:0]     out_nonce
);
    import shd_pkg::*;

    logic   valid_reg;
    state_t state_reg;
    sched_t sched_reg;
    state_t base_reg;
    logic [31:0] nonce_reg;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // Advance the round and the schedule
    always_ff @(posedge aclk) begin
        if (adv) begin
            state_reg <= sha_round(in_state, ROUND_K[ROUND], in_sched[0]);
            sched_reg <= sched_shift(in_sched);
            base_reg  <= in_base;
            nonce_reg <= in_nonce;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_sched = sched_reg;
    assign out_base  = base_reg;
    assign out_nonce = nonce_reg;
endmodule

// ===== rtl/shd_hash_chain.sv =====
// ----------------------------------------------------------------------------
// shd_hash_chain: 64-cell SHA-256 compression chain
// Runs one block per cycle while adv is high through 64 round cells and adds the chaining value.
// ----------------------------------------------------------------------------
module shd_hash_chain (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  shd_pkg::state_t in_base,
    input  shd_pkg::sched_t in_block,
    input  logic [31:0]     in_nonce,
    output logic            out_valid,
    output shd_pkg::state_t out_digest,
    output logic [31:0]     out_nonce
);
    import shd_pkg::*;

    logic   v   [0:NUM_ROUNDS];
    state_t st  [0:NUM_ROUNDS];
    sched_t sc  [0:NUM_ROUNDS];
    state_t bs  [0:NUM_ROUNDS];
    logic [31:0] nc [0:NUM_ROUNDS];

    assign v[0]  = in_valid;
    assign st[0] = in_base;
    assign sc[0] = in_block;
    assign bs[0] = in_base;
    assign nc[0] = in_nonce;

    for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_cell
        shd_round_cell #(.ROUND(r)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_valid (v[r]),
            .in_state (st[r]),
            .in_sched (sc[r]),
            .in_base  (bs[r]),
            .in_nonce (nc[r]),
            .out_valid(v[r+1]),
            .out_state(st[r+1]),
            .out_sched(sc[r+1]),
            .out_base (bs[r+1]),
            .out_nonce(nc[r+1])
        );
    end

    logic        valid_reg;
    state_t      digest_reg;
    logic [31:0] nonce_reg;

    // Register the feed-forward add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= v[NUM_ROUNDS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            digest_reg <= state_add(st[NUM_ROUNDS], bs[NUM_ROUNDS]);
            nonce_reg  <= nc[NUM_ROUNDS];
        end
    end

    assign out_valid  = valid_reg;
    assign out_digest = digest_reg;
    assign out_nonce  = nonce_reg;
endmodule

// ===== rtl/sha256d_nonce_hit_test.sv =====
// ----------------------------------------------------------------------------
// sha256d_nonce_hit_test: double SHA-256 nonce hit test
// Job words load the store; each nonce runs through two compression chains
// and a target compare, and a hit is emitted with its digest.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)                     tuser
// s_       in   word_index[4:0] word_value[36:5] nonce[68:37] command
// m_       out  hit_nonce, digest_words_01 .. digest_words_67  -
//
// One nonce enters per cycle while s_tready is high; it passes through two 64-cell
// round chains, their feed-forward add registers and the output register
// (the target compare is combinational in front of it). A stalled m_ side
// freezes the whole chain (s_tready low). A target word load waits with
// s_tready low until every nonce in flight has passed the compare.
// Reset clears the valid bits and the busy count only; job words are undefined until loaded.
// ----------------------------------------------------------------------------
module sha256d_nonce_hit_test (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // word_index, word_value, nonce, zero pad
    input  logic         s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata   // hit_nonce, digest 01, 23, 45, 67
);
    import shd_pkg::*;

    logic [4:0]  s_index;
    word_t       s_value;
    word_t       s_nonce;
    assign s_index = s_tdata[4:0];
    assign s_value = s_tdata[36:5];
    assign s_nonce = s_tdata[68:37];

    state_t mid_reg;
    word_t  tail_reg [0:2];
    word_t  tgt_reg  [0:7];

    logic out_valid_reg;
    logic [287:0] out_data_reg;
    logic adv;
    logic [7:0] busy_reg;
    logic tgt_wait;
    assign adv      = !out_valid_reg || m_tready;
    // Hold target loads while tests still need the current target
    assign tgt_wait = (s_tuser == CMD_LOAD) && (s_index >= IDX_TGT_BASE)
                      && (s_index <= IDX_LAST) && (busy_reg != 8'd0);
    assign s_tready = adv && !tgt_wait;

    logic load_acc;
    logic test_acc;
    assign load_acc = s_tvalid && s_tready && (s_tuser == CMD_LOAD);
    assign test_acc = s_tvalid && s_tready && (s_tuser == CMD_TEST);

    // Write job words
    always_ff @(posedge aclk) begin
        if (load_acc) begin
            if (s_index < IDX_TAIL_BASE) begin
                mid_reg[s_index[2:0]] <= s_value;
            end else if (s_index < IDX_TGT_BASE) begin
                tail_reg[2'(s_index - IDX_TAIL_BASE)] <= s_value;
            end else if (s_index <= IDX_LAST) begin
                tgt_reg[3'(s_index - IDX_TGT_BASE)] <= s_value;
            end
        end
    end

    // First block: tail, swapped nonce, padding for 80 bytes
    sched_t blk1;
    always_comb begin
        blk1     = '0;
        blk1[0]  = tail_reg[0];
        blk1[1]  = tail_reg[1];
        blk1[2]  = tail_reg[2];
        blk1[3]  = swap_bytes(s_nonce);
        blk1[4]  = 32'h80000000;
        blk1[15] = 32'd640;
    end

    logic   v1;
    state_t d1;
    word_t  n1;
    shd_hash_chain u_first (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(test_acc), .in_base(mid_reg), .in_block(blk1), .in_nonce(s_nonce),
        .out_valid(v1), .out_digest(d1), .out_nonce(n1)
    );

    sched_t blk2;
    always_comb begin
        blk2 = '0;
        for (int i = 0; i < 8; i++) begin
            blk2[i] = d1[i];
        end
        blk2[8]  = 32'h80000000;
        blk2[15] = 32'd256;
    end

    logic   v2;
    state_t d2;
    word_t  n2;
    shd_hash_chain u_second (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(v1), .in_base(INIT_H), .in_block(blk2), .in_nonce(n1),
        .out_valid(v2), .out_digest(d2), .out_nonce(n2)
    );

    // Count tests that have not yet reached the compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 8'd0;
        end else if (test_acc && !(adv && v2)) begin
            busy_reg <= busy_reg + 8'd1;
        end else if (!test_acc && adv && v2) begin
            busy_reg <= busy_reg - 8'd1;
        end
    end

    // Compare swapped digest with target as 256-bit numbers
    logic [255:0] hv;
    logic [255:0] tv;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            hv[32*i +: 32] = swap_bytes(d2[i]);
            tv[32*i +: 32] = tgt_reg[i];
        end
    end

    // Hold a hit until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v2 && (hv <= tv);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {d2[6], d2[7], d2[4], d2[5], d2[2], d2[3],
                             d2[0], d2[1], n2};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule
